@@ hw/rtl/dpe_pkg.sv @@
`default_nettype none
package dpe_pkg;

    localparam int MAX_HEIGHT_DEF = 32;
    localparam int NUM_ROUNDS     = 10;
    localparam int CFG_IDX_W      = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PARTY        = 3'd0,
        CFG_OUT_WIDTH    = 3'd1,
        CFG_TREE_HEIGHT  = 3'd2,
        CFG_ROOT_LOW     = 3'd3,
        CFG_ROOT_HIGH    = 3'd4,
        CFG_GAMMA_FIRST  = 3'd5,
        CFG_GAMMA_SECOND = 3'd6
    } t_cfg_idx;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_EVAL  = 1'b1
    } t_cmd;

    // Control for one pass through the round unit.
    typedef struct packed {
        logic [7:0] rcon;
        logic       last;
    } t_rnd_ctrl;

    localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Round constant for round r (1 to 10).
    function automatic logic [7:0] rcon(input logic [3:0] r);
        logic [7:0] v;
        v = 8'h00;
        unique case (r)
            4'd1:    v = 8'h01;
            4'd2:    v = 8'h02;
            4'd3:    v = 8'h04;
            4'd4:    v = 8'h08;
            4'd5:    v = 8'h10;
            4'd6:    v = 8'h20;
            4'd7:    v = 8'h40;
            4'd8:    v = 8'h80;
            4'd9:    v = 8'h1b;
            4'd10:   v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/dpe_if.sv @@
`default_nettype none
interface dpe_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [4:0]  level;
    logic [63:0] corr_seed_low;
    logic [63:0] corr_seed_high;
    logic        corr_flag_left;
    logic        corr_flag_right;
    logic [31:0] eval_index;

    modport source (output valid, command, level, corr_seed_low, corr_seed_high,
                    corr_flag_left, corr_flag_right, eval_index, input ready);
    modport sink (input valid, command, level, corr_seed_low, corr_seed_high,
                  corr_flag_left, corr_flag_right, eval_index, output ready);
endinterface

interface dpe_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] share_first;
    logic [63:0] share_second;

    modport source (output valid, share_first, share_second, input ready);
    modport sink (input valid, share_first, share_second, output ready);
endinterface

interface dpe_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [dpe_pkg::CFG_IDX_W-1:0]  index;
    logic [63:0]                    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/dpe_aes_round.sv @@
`default_nettype none
// One AES-128 round together with the matching key schedule step.
module dpe_aes_round (
    input  wire logic [127:0]       i_state,
    input  wire logic [127:0]       i_key,
    input  wire dpe_pkg::t_rnd_ctrl i_ctrl,
    output logic [127:0]            o_state,
    output logic [127:0]            o_key
);
    logic [7:0] s [16];
    logic [7:0] k [16];
    logic [7:0] n [16];
    logic [7:0] m [16];
    logic [7:0] nk [16];
    logic [7:0] t [4];

    always_comb begin
        for (int j = 0; j < 16; j++) begin
            s[j] = i_state[8*j +: 8];
            k[j] = i_key[8*j +: 8];
        end
        t[0] = dpe_pkg::SBOX[k[13]] ^ i_ctrl.rcon;
        t[1] = dpe_pkg::SBOX[k[14]];
        t[2] = dpe_pkg::SBOX[k[15]];
        t[3] = dpe_pkg::SBOX[k[12]];
        for (int j = 0; j < 4; j++) begin
            nk[j]      = k[j] ^ t[j];
            nk[4 + j]  = k[4 + j] ^ nk[j];
            nk[8 + j]  = k[8 + j] ^ nk[4 + j];
            nk[12 + j] = k[12 + j] ^ nk[8 + j];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                n[r + 4*c] = dpe_pkg::SBOX[s[r + 4*((c + r) % 4)]];
            end
        end
        for (int c = 0; c < 4; c++) begin
            if (i_ctrl.last) begin
                for (int r = 0; r < 4; r++) m[r + 4*c] = n[r + 4*c];
            end else begin
                m[4*c]     = n[4*c] ^ n[4*c] ^ n[4*c+1] ^ n[4*c+2] ^ n[4*c+3]
                             ^ dpe_pkg::xt(n[4*c] ^ n[4*c+1]);
                m[4*c + 1] = n[4*c+1] ^ n[4*c] ^ n[4*c+1] ^ n[4*c+2] ^ n[4*c+3]
                             ^ dpe_pkg::xt(n[4*c+1] ^ n[4*c+2]);
                m[4*c + 2] = n[4*c+2] ^ n[4*c] ^ n[4*c+1] ^ n[4*c+2] ^ n[4*c+3]
                             ^ dpe_pkg::xt(n[4*c+2] ^ n[4*c+3]);
                m[4*c + 3] = n[4*c+3] ^ n[4*c] ^ n[4*c+1] ^ n[4*c+2] ^ n[4*c+3]
                             ^ dpe_pkg::xt(n[4*c+3] ^ n[4*c]);
            end
        end
        for (int j = 0; j < 16; j++) begin
            o_state[8*j +: 8] = m[j] ^ nk[j];
            o_key[8*j +: 8]   = nk[j];
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/dpe_cw_mem.sv @@
`default_nettype none
// Correction word store: one 128-bit seed correction and two flag bits per level.
module dpe_cw_mem #(
    parameter int MAX_HEIGHT = dpe_pkg::MAX_HEIGHT_DEF,
    localparam int AW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [127:0]  i_wr_seed,
    input  wire logic [1:0]    i_wr_flags,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic [127:0]       o_rd_seed,
    output logic [1:0]         o_rd_flags
);
    logic [129:0] r_mem [MAX_HEIGHT];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_flags, i_wr_seed};
        end
        {o_rd_flags, o_rd_seed} <= r_mem[i_rd_addr];
    end
endmodule
`default_nettype wire

@@ hw/rtl/dpf_point_eval_top.sv @@
`default_nettype none
// Write item: one transfer, the block stays ready and gives no result.
// Evaluate item: h levels, h the clamped tree height, then a final add and a negation step;
// each level runs two AES-128 blocks of ten rounds on one shared round unit, each after a
// load state. One item at a time; the result register frees the input.
// Reset (synchronous, active low) clears the sequencer, the result valid and the configuration
// registers; the correction word store is not cleared.
module dpf_point_eval_top #(
    parameter int MAX_HEIGHT = dpe_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dpe_in_if.sink     i_in,
    dpe_out_if.source  o_out,
    dpe_cfg_if.sink    i_cfg
);
    localparam int AW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int LW = $clog2(MAX_HEIGHT + 1);
    localparam int SW = (LW > 6) ? LW : 6;

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LOAD  = 5'b00010,
        S_ROUND = 5'b00100,
        S_FINAL = 5'b01000,
        S_NEG   = 5'b10000
    } t_state;

    t_state        r_state;
    logic          r_party;
    logic [6:0]    r_out_width;
    logic [5:0]    r_tree_height;
    logic [127:0]  r_root;
    logic [63:0]   r_gamma0;
    logic [63:0]   r_gamma1;

    logic [127:0]  r_seed;
    logic          r_flag;
    logic [LW-1:0] r_lvl;
    logic [LW-1:0] r_h;
    logic [31:0]   r_idx;
    logic          r_bit;
    logic          r_blk;
    logic [3:0]    r_rnd;
    logic [127:0]  r_st;
    logic [127:0]  r_rk;
    logic [127:0]  r_cta;
    logic [63:0]   r_e0;
    logic [63:0]   r_e1;
    logic          r_ovalid;
    logic [63:0]   r_share0;
    logic [63:0]   r_share1;

    logic          in_xfer;
    logic [LW-1:0] h_clamped;
    logic [SW-1:0] sh;
    logic          cur_bit;
    logic [127:0]  pt;
    dpe_pkg::t_rnd_ctrl rnd_ctrl;
    logic [127:0]  rnd_state;
    logic [127:0]  rnd_key;
    logic [127:0]  cw_seed;
    logic [1:0]    cw_flags;
    logic          wr_en;
    logic [6:0]    width;
    logic [3:0]    nbytes;
    logic [63:0]   mask;
    logic [63:0]   word1;
    logic          out_free;

    // The input side is open only while the sequencer is idle.
    assign i_in.ready = (r_state == S_IDLE);
    assign in_xfer    = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid        = r_ovalid;
    assign o_out.share_first  = r_share0;
    assign o_out.share_second = r_share1;
    assign out_free = !r_ovalid || o_out.ready;

    // Heights above the store depth walk the full depth.
    assign h_clamped = (8'(r_tree_height) > 8'(MAX_HEIGHT)) ? LW'(MAX_HEIGHT)
                                                            : LW'(r_tree_height);

    // Index bit for the current level, most significant used bit first.
    // Bits above the 32-bit index read as zero.
    assign sh      = SW'(r_h) - SW'(r_lvl) - SW'(1);
    assign cur_bit = (sh < SW'(32)) ? r_idx[sh[4:0]] : 1'b0;

    // Plaintext is 2b for the seed block and 2b+1 for the flag block.
    assign pt = {120'd0, 6'd0, r_bit, r_blk};

    assign rnd_ctrl.rcon = dpe_pkg::rcon(r_rnd);
    assign rnd_ctrl.last = (r_rnd == 4'(dpe_pkg::NUM_ROUNDS));

    dpe_aes_round u_round (
        .i_state (r_st),
        .i_key   (r_rk),
        .i_ctrl  (rnd_ctrl),
        .o_state (rnd_state),
        .o_key   (rnd_key)
    );

    assign wr_en = in_xfer && (i_in.command == dpe_pkg::CMD_WRITE)
                   && (32'(i_in.level) < 32'(MAX_HEIGHT));

    dpe_cw_mem #(
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cw_mem (
        .i_clk      (i_clk),
        .i_wr_en    (wr_en),
        .i_wr_addr  (AW'(i_in.level)),
        .i_wr_seed  ({i_in.corr_seed_high, i_in.corr_seed_low}),
        .i_wr_flags ({i_in.corr_flag_right, i_in.corr_flag_left}),
        .i_rd_addr  (r_lvl[AW-1:0]),
        .o_rd_seed  (cw_seed),
        .o_rd_flags (cw_flags)
    );

    // Output group width: zero acts as one, anything above 64 as 64.
    assign width  = (r_out_width == 7'd0) ? 7'd1
                  : ((r_out_width > 7'd64) ? 7'd64 : r_out_width);
    assign nbytes = 4'((8'(width) + 8'd7) >> 3);
    assign mask   = (width == 7'd64) ? {64{1'b1}} : ((64'd1 << width[5:0]) - 64'd1);

    // The second element starts at byte nbytes of the final seed.
    always_comb begin
        unique case (nbytes)
            4'd1:    word1 = r_seed[71:8];
            4'd2:    word1 = r_seed[79:16];
            4'd3:    word1 = r_seed[87:24];
            4'd4:    word1 = r_seed[95:32];
            4'd5:    word1 = r_seed[103:40];
            4'd6:    word1 = r_seed[111:48];
            4'd7:    word1 = r_seed[119:56];
            default: word1 = r_seed[127:64];
        endcase
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_party       <= 1'b0;
            r_out_width   <= 7'd64;
            r_tree_height <= 6'd32;
            r_root        <= '0;
            r_gamma0      <= '0;
            r_gamma1      <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                dpe_pkg::CFG_PARTY:        r_party       <= i_cfg.data[0];
                dpe_pkg::CFG_OUT_WIDTH:    r_out_width   <= i_cfg.data[6:0];
                dpe_pkg::CFG_TREE_HEIGHT:  r_tree_height <= i_cfg.data[5:0];
                dpe_pkg::CFG_ROOT_LOW:     r_root[63:0]  <= i_cfg.data;
                dpe_pkg::CFG_ROOT_HIGH:    r_root[127:64] <= i_cfg.data;
                dpe_pkg::CFG_GAMMA_FIRST:  r_gamma0      <= i_cfg.data;
                dpe_pkg::CFG_GAMMA_SECOND: r_gamma1      <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Sequencer control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            // A new result is loaded when the register is free; otherwise a waiting
            // result stays until its transfer.
            r_ovalid <= ((r_state == S_NEG) && out_free) || (r_ovalid && !o_out.ready);
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer && (i_in.command == dpe_pkg::CMD_EVAL)) begin
                        r_state <= (h_clamped == '0) ? S_FINAL : S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    if (rnd_ctrl.last) begin
                        if (!r_blk) begin
                            r_state <= S_LOAD;
                        end else if (r_lvl + LW'(1) == r_h) begin
                            r_state <= S_FINAL;
                        end else begin
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_FINAL: begin
                    r_state <= S_NEG;
                end
                S_NEG: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_seed <= r_root;
                r_flag <= r_party;
                r_lvl  <= '0;
                r_h    <= h_clamped;
                r_idx  <= i_in.eval_index;
                r_blk  <= 1'b0;
            end
            S_LOAD: begin
                // Initial key addition; the seed is the cipher key.
                if (!r_blk) begin
                    r_bit <= cur_bit;
                    r_st  <= r_seed ^ {120'd0, 6'd0, cur_bit, 1'b0};
                end else begin
                    r_st  <= r_seed ^ pt;
                end
                r_rk  <= r_seed;
                r_rnd <= 4'd1;
            end
            S_ROUND: begin
                r_st  <= rnd_state;
                r_rk  <= rnd_key;
                r_rnd <= r_rnd + 4'd1;
                if (rnd_ctrl.last) begin
                    if (!r_blk) begin
                        r_cta <= rnd_state;
                        r_blk <= 1'b1;
                    end else begin
                        // Level done: apply the correction word when the flag is set.
                        r_seed <= r_cta ^ (r_flag ? cw_seed : 128'd0);
                        r_flag <= rnd_state[0] ^ (r_flag & cw_flags[r_bit]);
                        r_lvl  <= r_lvl + LW'(1);
                        r_blk  <= 1'b0;
                    end
                end
            end
            S_FINAL: begin
                r_e0 <= r_seed[63:0] + (r_flag ? r_gamma0 : 64'd0);
                r_e1 <= word1 + (r_flag ? r_gamma1 : 64'd0);
            end
            S_NEG: begin
                if (out_free) begin
                    r_share0 <= (r_party ? (64'd0 - r_e0) : r_e0) & mask;
                    r_share1 <= (r_party ? (64'd0 - r_e1) : r_e1) & mask;
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

@@ hw/rtl/dpe_checker.sv @@
`default_nettype none
module dpe_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic in_command,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic [63:0] out_share_first
);
    // A result waiting for the sink holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_share_first))
        else $error("result changed while stalled");

    // An evaluate transfer makes the block busy.
    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready && in_command |=> !in_ready)
        else $error("input open during evaluation");

    // A write transfer leaves the block ready.
    a_write_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready && !in_command |=> in_ready)
        else $error("write transfer made the block busy");

    // A new result appears only at the end of an evaluation.
    a_result_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result without evaluation");
endmodule

bind dpf_point_eval_top dpe_checker u_dpe_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .in_valid        (i_in.valid),
    .in_ready        (i_in.ready),
    .in_command      (i_in.command),
    .out_valid       (o_out.valid),
    .out_ready       (o_out.ready),
    .out_share_first (o_out.share_first)
);
`default_nettype wire

@@ dv/tb_dpf_point_eval_top.sv @@
`timescale 1ns / 1ps
module tb_dpf_point_eval_top;

    // Clamped height is at most 32, the depth of the correction word store.
    localparam int LEVELS     = 32;
    localparam int EVAL_DRAIN = 800;
    localparam int CYCLE_CAP  = 3000000;

    typedef struct {
        dpe_pkg::t_cmd cmd;
        logic [4:0]    level;
        logic [63:0]   seed_lo;
        logic [63:0]   seed_hi;
        logic          flag_l;
        logic          flag_r;
        logic [31:0]   index;
    } t_item;

    typedef struct {
        logic [63:0] first;
        logic [63:0] second;
    } t_shares;

    // A directed row is either a register write or an input item. Where
    // typed is set, the expected shares are written into the row by hand.
    typedef enum logic {ROW_REG, ROW_ITEM} t_row_kind;

    typedef struct {
        t_row_kind         kind;
        dpe_pkg::t_cfg_idx reg_idx;
        logic [63:0]       reg_val;
        t_item             it;
        logic              typed;
        t_shares           exp;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    dpe_in_if  in_if ();
    dpe_out_if out_if ();
    dpe_cfg_if cfg_if ();

    dpf_point_eval_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Shadow copy of the configuration and of the correction word store.
    logic        m_party;
    logic [6:0]  m_width;
    logic [5:0]  m_height;
    logic [63:0] m_root_lo, m_root_hi, m_gamma_first, m_gamma_second;
    logic [63:0] m_corr_lo [LEVELS];
    logic [63:0] m_corr_hi [LEVELS];
    logic [1:0]  m_corr_flag [LEVELS];

    t_shares share_q [$];
    int      n_errors;
    int      cycles;
    int      send_idle_pct;
    int      recv_stall_pct;
    int      hold_off;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run guard: a hung block or handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycles = cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("dpf_point_eval_top: mismatch");
            $finish;
        end
    end

    function automatic logic [7:0] gf_double(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // AES-128 of one block, the round keys being derived alongside the rounds.
    function automatic logic [127:0] aes128(input logic [127:0] key, input logic [127:0] pt);
        logic [127:0] rk, st, nx;
        logic [31:0]  t;
        logic [7:0]   rc, a0, a1, a2, a3, x;
        int           r, c, k;
        rk = key;
        st = pt ^ rk;
        rc = 8'h01;
        for (r = 1; r <= 10; r++) begin
            t = rk[127:96];
            t = {dpe_pkg::SBOX[t[7:0]], dpe_pkg::SBOX[t[31:24]], dpe_pkg::SBOX[t[23:16]],
                 dpe_pkg::SBOX[t[15:8]] ^ rc};
            rk[31:0]   = rk[31:0] ^ t;
            rk[63:32]  = rk[63:32] ^ rk[31:0];
            rk[95:64]  = rk[95:64] ^ rk[63:32];
            rk[127:96] = rk[127:96] ^ rk[95:64];
            rc = gf_double(rc);
            for (c = 0; c < 4; c++)
                for (k = 0; k < 4; k++)
                    nx[8*(k+4*c) +: 8] = dpe_pkg::SBOX[st[8*(k + 4*((c+k) & 3)) +: 8]];
            if (r < 10) begin
                for (c = 0; c < 4; c++) begin
                    a0 = nx[32*c +: 8];
                    a1 = nx[32*c+8 +: 8];
                    a2 = nx[32*c+16 +: 8];
                    a3 = nx[32*c+24 +: 8];
                    x  = a0 ^ a1 ^ a2 ^ a3;
                    nx[32*c +: 8]    = a0 ^ x ^ gf_double(a0 ^ a1);
                    nx[32*c+8 +: 8]  = a1 ^ x ^ gf_double(a1 ^ a2);
                    nx[32*c+16 +: 8] = a2 ^ x ^ gf_double(a2 ^ a3);
                    nx[32*c+24 +: 8] = a3 ^ x ^ gf_double(a3 ^ a0);
                end
            end
            st = nx ^ rk;
        end
        return st;
    endfunction

    // Walks the tree for one index and forms this party's two shares.
    function automatic t_shares point_shares(input logic [31:0] index);
        t_shares      s;
        logic [127:0] seed, ct_seed, ct_flag;
        logic [63:0]  mask;
        logic         flag, t, b;
        int           h, w, nb, i;
        h = (m_height > LEVELS) ? LEVELS : int'(m_height);
        w = (m_width == 0) ? 1 : ((m_width > 64) ? 64 : int'(m_width));
        seed = {m_root_hi, m_root_lo};
        flag = m_party;
        for (i = 0; i < h; i++) begin
            b = index[h-1-i];
            ct_seed = aes128(seed, 128'(2 * b));
            ct_flag = aes128(seed, 128'(2 * b + 1));
            seed = ct_seed;
            t = ct_flag[0];
            if (flag) begin
                seed = seed ^ {m_corr_hi[i], m_corr_lo[i]};
                t = t ^ m_corr_flag[i][b];
            end
            flag = t;
        end
        mask = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
        nb = (w + 7) / 8;
        s.first  = seed[63:0];
        s.second = seed[8*nb +: 64];
        if (flag) begin
            s.first  = s.first + m_gamma_first;
            s.second = s.second + m_gamma_second;
        end
        if (m_party) begin
            s.first  = -s.first;
            s.second = -s.second;
        end
        s.first  = s.first & mask;
        s.second = s.second & mask;
        return s;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("%0t: %s got %h, expected %h", $realtime, what, got, want);
        n_errors = n_errors + 1;
    endtask

    // Result side: ready follows the stall rate unless a long hold-off is running.
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off > 0) begin
                hold_off = hold_off - 1;
                out_if.ready = 1'b0;
            end else begin
                out_if.ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_shares want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (share_q.size() == 0) begin
                report("unexpected result, share_first", out_if.share_first, '0);
            end else begin
                want = share_q.pop_front();
                if (out_if.share_first !== want.first)
                    report("share_first", out_if.share_first, want.first);
                if (out_if.share_second !== want.second)
                    report("share_second", out_if.share_second, want.second);
            end
        end
    end

    // Offers one item and waits for its transfer. Valid is left high so that
    // back-to-back items need no gap; idle_items lowers it.
    task automatic push_item(input t_item it, input logic typed, input t_shares exp);
        @(negedge i_clk);
        if ($urandom_range(99) < send_idle_pct) begin
            in_if.valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        in_if.command         = it.cmd;
        in_if.level           = it.level;
        in_if.corr_seed_low   = it.seed_lo;
        in_if.corr_seed_high  = it.seed_hi;
        in_if.corr_flag_left  = it.flag_l;
        in_if.corr_flag_right = it.flag_r;
        in_if.eval_index      = it.index;
        in_if.valid           = 1'b1;
        do @(posedge i_clk); while (!in_if.ready);
        if (it.cmd == dpe_pkg::CMD_WRITE) begin
            m_corr_lo[it.level]   = it.seed_lo;
            m_corr_hi[it.level]   = it.seed_hi;
            m_corr_flag[it.level] = {it.flag_r, it.flag_l};
        end else begin
            share_q.push_back(typed ? exp : point_shares(it.index));
        end
    endtask

    task automatic idle_items();
        @(negedge i_clk);
        in_if.valid = 1'b0;
    endtask

    task automatic wait_results();
        idle_items();
        while (share_q.size() != 0) @(posedge i_clk);
    endtask

    // Register writes happen only with the block idle.
    task automatic write_reg(input dpe_pkg::t_cfg_idx idx, input logic [63:0] val);
        wait_results();
        repeat (20) @(negedge i_clk);
        cfg_if.index = idx;
        cfg_if.data  = val;
        cfg_if.valid = 1'b1;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            dpe_pkg::CFG_PARTY:        m_party = val[0];
            dpe_pkg::CFG_OUT_WIDTH:    m_width = val[6:0];
            dpe_pkg::CFG_TREE_HEIGHT:  m_height = val[5:0];
            dpe_pkg::CFG_ROOT_LOW:     m_root_lo = val;
            dpe_pkg::CFG_ROOT_HIGH:    m_root_hi = val;
            dpe_pkg::CFG_GAMMA_FIRST:  m_gamma_first = val;
            dpe_pkg::CFG_GAMMA_SECOND: m_gamma_second = val;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    function automatic t_item random_item(input int write_pct);
        t_item it;
        it.cmd     = ($urandom_range(99) < write_pct) ? dpe_pkg::CMD_WRITE : dpe_pkg::CMD_EVAL;
        it.level   = 5'($urandom_range(LEVELS - 1));
        it.seed_lo = {$urandom, $urandom};
        it.seed_hi = {$urandom, $urandom};
        it.flag_l  = 1'($urandom);
        it.flag_r  = 1'($urandom);
        it.index   = $urandom;
        return it;
    endfunction

    function automatic t_item write_row(input logic [4:0] lv, input logic [63:0] lo,
                                        input logic [63:0] hi, input logic fl, input logic fr);
        t_item it;
        it = '{dpe_pkg::CMD_WRITE, lv, lo, hi, fl, fr, 32'h0};
        return it;
    endfunction

    function automatic t_item eval_row(input logic [31:0] index);
        t_item it;
        it = '{dpe_pkg::CMD_EVAL, 5'd0, 64'h0, 64'h0, 1'b0, 1'b0, index};
        return it;
    endfunction

    t_shares none;

    function automatic t_row reg_row(input dpe_pkg::t_cfg_idx idx, input logic [63:0] val);
        t_row r;
        r = '{ROW_REG, idx, val, eval_row(0), 1'b0, none};
        return r;
    endfunction

    function automatic t_row item_row(input t_item it, input logic typed, input t_shares exp);
        t_row r;
        r = '{ROW_ITEM, dpe_pkg::CFG_PARTY, 64'h0, it, typed, exp};
        return r;
    endfunction

    // A fresh setting for a random phase: mostly shallow trees, now and then
    // the full height, a zero height or the clamped widths.
    task automatic random_setting();
        int pick;
        write_reg(dpe_pkg::CFG_PARTY, 64'($urandom_range(1)));
        pick = $urandom_range(9);
        write_reg(dpe_pkg::CFG_OUT_WIDTH, (pick == 0) ? 64'd0 : (pick == 1) ? 64'd127 :
                                          (pick == 2) ? 64'd64 : 64'($urandom_range(1, 64)));
        pick = $urandom_range(9);
        write_reg(dpe_pkg::CFG_TREE_HEIGHT, (pick == 0) ? 64'd32 : (pick == 1) ? 64'd0 :
                                            64'($urandom_range(1, 8)));
        write_reg(dpe_pkg::CFG_ROOT_LOW, {$urandom, $urandom});
        write_reg(dpe_pkg::CFG_ROOT_HIGH, {$urandom, $urandom});
        write_reg(dpe_pkg::CFG_GAMMA_FIRST, {$urandom, $urandom});
        write_reg(dpe_pkg::CFG_GAMMA_SECOND, {$urandom, $urandom});
    endtask

    t_row rows [$];
    int   phase, n, lv;

    initial begin
        n_errors = 0;
        cycles = 0;
        hold_off = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        none = '{64'h0, 64'h0};
        m_party = 1'b0;
        m_width = 7'd64;
        m_height = 6'd32;
        m_root_lo = '0;
        m_root_hi = '0;
        m_gamma_first = '0;
        m_gamma_second = '0;
        in_if.valid = 1'b0;
        in_if.command = dpe_pkg::CMD_WRITE;
        in_if.level = '0;
        in_if.corr_seed_low = '0;
        in_if.corr_seed_high = '0;
        in_if.corr_flag_left = 1'b0;
        in_if.corr_flag_right = 1'b0;
        in_if.eval_index = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = dpe_pkg::CFG_PARTY;
        cfg_if.data = '0;

        // Synchronous reset, asserted from the start and then released for good.
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // The store is undefined after reset, so every level gets a correction
        // word before the first walk can read one.
        for (lv = 0; lv < LEVELS; lv++) begin
            t_item it;
            it = random_item(100);
            it.level = 5'(lv);
            push_item(it, 1'b0, none);
        end

        // Directed part. With no level walked the shares are the root seed
        // halves; for party 1 with the flag set they become -(root + 1), which
        // is the bitwise inverse of the root.
        rows.push_back(item_row(write_row(5'd0, '1, '1, 1'b1, 1'b1), 0, none));
        rows.push_back(item_row(write_row(5'd31, '0, '0, 1'b0, 1'b0), 0, none));
        rows.push_back(item_row(write_row(5'd5, 64'haaaa5555aaaa5555, 64'h5555aaaa5555aaaa,
                                          1'b1, 1'b0), 0, none));
        rows.push_back(reg_row(dpe_pkg::CFG_TREE_HEIGHT, 64'd0));
        rows.push_back(reg_row(dpe_pkg::CFG_ROOT_LOW, 64'h0123456789abcdef));
        rows.push_back(reg_row(dpe_pkg::CFG_ROOT_HIGH, 64'hfedcba9876543210));
        rows.push_back(item_row(eval_row(32'h0), 1,
                                '{64'h0123456789abcdef, 64'hfedcba9876543210}));
        rows.push_back(reg_row(dpe_pkg::CFG_PARTY, 64'd1));
        rows.push_back(reg_row(dpe_pkg::CFG_GAMMA_FIRST, 64'd1));
        rows.push_back(reg_row(dpe_pkg::CFG_GAMMA_SECOND, 64'd1));
        rows.push_back(item_row(eval_row(32'hffffffff), 1,
                                '{64'hfedcba9876543210, 64'h0123456789abcdef}));
        rows.push_back(reg_row(dpe_pkg::CFG_OUT_WIDTH, 64'd0));
        rows.push_back(item_row(eval_row(32'hffffffff), 0, none));
        rows.push_back(reg_row(dpe_pkg::CFG_OUT_WIDTH, 64'd127));
        rows.push_back(item_row(eval_row(32'h0), 0, none));
        rows.push_back(reg_row(dpe_pkg::CFG_TREE_HEIGHT, 64'd63));
        rows.push_back(item_row(eval_row(32'h0), 0, none));
        rows.push_back(item_row(eval_row(32'hffffffff), 0, none));
        rows.push_back(reg_row(dpe_pkg::CFG_OUT_WIDTH, 64'd1));
        rows.push_back(reg_row(dpe_pkg::CFG_TREE_HEIGHT, 64'd1));
        rows.push_back(item_row(eval_row(32'h1), 0, none));
        rows.push_back(item_row(eval_row(32'hfffffffe), 0, none));
        rows.push_back(reg_row(dpe_pkg::CFG_PARTY, 64'd0));
        rows.push_back(reg_row(dpe_pkg::CFG_OUT_WIDTH, 64'd13));
        rows.push_back(reg_row(dpe_pkg::CFG_TREE_HEIGHT, 64'd32));
        rows.push_back(item_row(eval_row(32'h80000001), 0, none));
        rows.push_back(item_row(eval_row(32'h7ffffffe), 0, none));
        foreach (rows[i]) begin
            if (rows[i].kind == ROW_REG)
                write_reg(rows[i].reg_idx, rows[i].reg_val);
            else
                push_item(rows[i].it, rows[i].typed, rows[i].exp);
        end

        // Random phases, each with its own setting and idling pattern.
        for (phase = 0; phase < 4; phase++) begin
            random_setting();
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            for (n = 0; n < 95; n++) begin
                // The result side holds off for a long stretch while items keep
                // coming, so the block fills and stalls its input.
                if (phase == 0 && n == 20)
                    hold_off = 3000;
                // The sender pauses until every outstanding result is back.
                if (n == 60)
                    wait_results();
                push_item(random_item(40), 1'b0, none);
            end
        end

        wait_results();
        repeat (EVAL_DRAIN) @(posedge i_clk);
        if (n_errors == 0)
            $display("dpf_point_eval_top: match");
        else
            $display("dpf_point_eval_top: mismatch");
        $finish;
    end

endmodule
